/* sv/gld_pkg.sv */
package gld_pkg;

  localparam int DICT_SIZE     = 4096;
  localparam int MAX_CODE_BITS = 12;
  localparam int STACK_DEPTH   = 4096;

  localparam int DICT_AW  = $clog2(DICT_SIZE);
  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int CODE_W   = MAX_CODE_BITS;
  localparam int CNT_W    = 13;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 16;

  localparam logic [CNT_W-1:0] PREV_NONE = 13'h1FFF;

  typedef enum logic [CFG_AW-1:0] {
    CFG_CODE_SIZE  = 2'd0,
    CFG_WIDTH      = 2'd1,
    CFG_HEIGHT     = 2'd2,
    CFG_INTERLACED = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WALK,
    ST_FIN,
    ST_POP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic        byte_taken;
    logic        pixel_valid;
    logic [7:0]  pixel_value;
    logic [31:0] pixel_offset;
    logic        pixel_in_image;
    logic        need_data;
    logic        stream_ended;
    logic        stream_error;
  } out_t;

  typedef struct packed {
    logic [CODE_W-1:0] prefix;
    logic [7:0]        suffix;
  } dict_entry_t;

  typedef struct packed {
    logic [31:0] offset;
    logic        in_image;
  } pos_info_t;

  // Minimum code size clamped to 2..8.
  function automatic logic [3:0] eff_size(input logic [3:0] cs);
    logic [3:0] r;
    r = cs;
    if (cs < 4'd2) r = 4'd2;
    if (cs > 4'd8) r = 4'd8;
    return r;
  endfunction

  function automatic logic [8:0] roots_of(input logic [3:0] cs);
    return 9'd1 << eff_size(cs);
  endfunction

  // First row of interlace passes 2 to 4.
  function automatic logic [3:0] pass_start(input logic [2:0] p);
    logic [3:0] r;
    r = 4'd1;
    if (p == 3'd2) r = 4'd4;
    if (p == 3'd3) r = 4'd2;
    return r;
  endfunction

endpackage

/* sv/gif_lzw_pixel_decoder_core.sv */
// GIF LZW pixel decoder.
// Input channel (in_valid_i / in_stall_o, payload in_req_i): each request either
// pushes one compressed byte (op 0) into a 24-bit bit store, or pulls one pixel (op 1).
// Output channel (out_valid_o / out_stall_i, payload out_rsp_o): exactly one
// response per request, in order, held stable while out_stall_i is high.
// Config port: cfg_we_i with cfg_addr_i / cfg_wdata_i, write only while idle.
// Sequence: a push is answered straight from IDLE; a pull with stacked bytes goes
// through POP (stack read) and EMIT (offset); a pull with an empty stack goes through
// DECODE for each code read, WALK for each dictionary entry walked (memory read loop),
// then FIN and EMIT. Throughput: one push per cycle while out_stall_i is low.
// One request is in flight at a time. A waiting response holds off new requests
// only while out_stall_i is high; the next request is taken in the same cycle
// the response is taken.
// Reset: dictionary restarted for code size 8, image 1x1, plain row order,
// flags clear. Dictionary and stack memories are not cleared; no clearing pass.
module gif_lzw_pixel_decoder_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  gld_pkg::in_t                 in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output gld_pkg::out_t                out_rsp_o,
  input  logic                         cfg_we_i,
  input  logic [gld_pkg::CFG_AW-1:0]   cfg_addr_i,
  input  logic [gld_pkg::CFG_DW-1:0]   cfg_wdata_i
);

  localparam int CW = gld_pkg::CODE_W;
  localparam int NW = gld_pkg::CNT_W;

  gld_pkg::state_e state_q, state_d;

  // configuration
  logic [3:0]  code_size_q;
  logic [15:0] width_q, height_q;
  logic        interlaced_q;

  // decoder state
  logic [NW-1:0] nfc_q, nfc_d;
  logic [3:0]    cw_q, cw_d;
  logic [NW-1:0] prev_q, prev_d;
  logic [7:0]    first_q, first_d;
  logic [23:0]   store_q, store_d;
  logic [4:0]    bcnt_q, bcnt_d;
  logic [NW-1:0] sc_q, sc_d;
  logic [1:0]    status_q, status_d;   // [0] ended, [1] error
  logic [CW-1:0] cur_q, cur_d;
  logic [CW-1:0] code_q, code_d;
  logic [7:0]    pix_q, pix_d;
  logic          from_stack_q, from_stack_d;

  logic          out_valid_q, out_valid_d;
  gld_pkg::out_t out_q, out_d;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // memories
  logic                         dict_we, dict_re;
  logic [gld_pkg::DICT_AW-1:0]  dict_waddr, dict_raddr;
  gld_pkg::dict_entry_t         dict_wdata, dict_rdata;
  logic                         stk_we, stk_re;
  logic [gld_pkg::STACK_AW-1:0] stk_waddr, stk_raddr;
  logic [7:0]                   stk_wdata, stk_rdata;

  gld_ram #(.WIDTH($bits(gld_pkg::dict_entry_t)), .DEPTH(gld_pkg::DICT_SIZE)) u_dict (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (dict_waddr),
    .wdata_i (dict_wdata),
    .re_i    (dict_re),
    .raddr_i (dict_raddr),
    .rdata_o (dict_rdata)
  );

  gld_ram #(.WIDTH(8), .DEPTH(gld_pkg::STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  logic               pos_adv;
  gld_pkg::pos_info_t pos_info;

  gld_pos u_pos (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .width_i      (width_q),
    .height_i     (height_q),
    .interlaced_i (interlaced_q),
    .advance_i    (pos_adv),
    .info_o       (pos_info)
  );

  // chain continues while the link is not a root and the stack has room
  function automatic logic walk_more(input logic [CW-1:0] c, input logic [NW-1:0] s,
                                     input logic [8:0] r);
    return (c >= CW'(r)) && (s < NW'(gld_pkg::STACK_DEPTH - 1));
  endfunction

  // shared decode terms
  logic [8:0]    roots;
  logic [23:0]   mask;
  logic [CW-1:0] code;
  logic [NW-1:0] code_x;
  logic          have_bits, is_clear, is_end, is_kwk, is_bad;
  logic [CW-1:0] cur_start;
  logic [NW-1:0] sc_start;
  logic          start_walk, more_walk;

  assign roots      = gld_pkg::roots_of(code_size_q);
  assign mask       = (24'd1 << cw_q) - 24'd1;
  assign code       = CW'(store_q & mask);
  assign code_x     = NW'(code);
  assign have_bits  = bcnt_q >= {1'b0, cw_q};
  assign is_clear   = code_x == NW'(roots);
  assign is_end     = code_x == NW'(roots) + NW'(1);
  assign is_kwk     = code_x == nfc_q;
  assign is_bad     = (code_x > nfc_q) || (is_kwk && prev_q == gld_pkg::PREV_NONE);
  assign cur_start  = is_kwk ? prev_q[CW-1:0] : code;
  assign sc_start   = is_kwk ? NW'(1) : '0;
  assign start_walk = walk_more(cur_start, sc_start, roots);
  assign more_walk  = walk_more(dict_rdata.prefix, sc_q + NW'(1), roots);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gld_pkg::ST_IDLE: begin
        if (in_acc && in_req_i.op) begin
          state_d = (sc_q != '0) ? gld_pkg::ST_POP : gld_pkg::ST_DECODE;
        end
      end
      gld_pkg::ST_DECODE: begin
        if (status_q != 2'b00 || !have_bits || is_end || is_bad) begin
          state_d = gld_pkg::ST_IDLE;
        end else if (!is_clear) begin
          state_d = start_walk ? gld_pkg::ST_WALK : gld_pkg::ST_FIN;
        end
      end
      gld_pkg::ST_WALK: begin
        if (!more_walk) state_d = gld_pkg::ST_FIN;
      end
      gld_pkg::ST_FIN:  state_d = gld_pkg::ST_EMIT;
      gld_pkg::ST_POP:  state_d = gld_pkg::ST_EMIT;
      gld_pkg::ST_EMIT: state_d = gld_pkg::ST_IDLE;
      default:          state_d = gld_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic [NW-1:0] nfc_n;
    nfc_n        = nfc_q;
    nfc_d        = nfc_q;
    cw_d         = cw_q;
    prev_d       = prev_q;
    first_d      = first_q;
    store_d      = store_q;
    bcnt_d       = bcnt_q;
    sc_d         = sc_q;
    status_d     = status_q;
    cur_d        = cur_q;
    code_d       = code_q;
    pix_d        = pix_q;
    from_stack_d = from_stack_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    dict_we      = 1'b0;
    dict_waddr   = nfc_q[gld_pkg::DICT_AW-1:0];
    dict_wdata   = '0;
    dict_re      = 1'b0;
    dict_raddr   = cur_start[gld_pkg::DICT_AW-1:0];
    stk_we       = 1'b0;
    stk_waddr    = sc_q[gld_pkg::STACK_AW-1:0];
    stk_wdata    = first_q;
    stk_re       = 1'b0;
    stk_raddr    = gld_pkg::STACK_AW'(sc_q - NW'(1));
    pos_adv      = 1'b0;

    unique case (state_q)
      gld_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!in_req_i.op) begin
            out_d       = '0;
            out_valid_d = 1'b1;
            if (bcnt_q <= 5'd16) begin
              store_d = store_q | (24'(in_req_i.data_byte) << bcnt_q);
              bcnt_d  = bcnt_q + 5'd8;
              out_d.byte_taken = 1'b1;
            end
            out_d.stream_ended = status_q[0];
            out_d.stream_error = status_q[1];
          end else if (sc_q != '0) begin
            stk_re       = 1'b1;
            sc_d         = sc_q - NW'(1);
            from_stack_d = 1'b1;
          end
        end
      end
      gld_pkg::ST_DECODE: begin
        out_d = '0;
        if (status_q != 2'b00) begin
          out_valid_d = 1'b1;
        end else if (!have_bits) begin
          out_valid_d     = 1'b1;
          out_d.need_data = 1'b1;
        end else begin
          store_d = store_q >> cw_q;
          bcnt_d  = bcnt_q - {1'b0, cw_q};
          if (is_clear) begin
            nfc_d  = NW'(roots) + NW'(2);
            cw_d   = gld_pkg::eff_size(code_size_q) + 4'd1;
            prev_d = gld_pkg::PREV_NONE;
          end else if (is_end) begin
            status_d[0] = 1'b1;
            out_valid_d = 1'b1;
          end else if (is_bad) begin
            status_d[1] = 1'b1;
            sc_d        = '0;
            out_valid_d = 1'b1;
          end else begin
            // KwKwK: the string ends in its own first byte
            stk_we    = is_kwk;
            stk_waddr = '0;
            sc_d      = sc_start;
            cur_d     = cur_start;
            code_d    = code;
            dict_re   = start_walk;
          end
        end
        out_d.stream_ended = status_d[0];
        out_d.stream_error = status_d[1];
      end
      gld_pkg::ST_WALK: begin
        stk_we     = 1'b1;
        stk_wdata  = dict_rdata.suffix;
        sc_d       = sc_q + NW'(1);
        cur_d      = dict_rdata.prefix;
        dict_re    = more_walk;
        dict_raddr = dict_rdata.prefix[gld_pkg::DICT_AW-1:0];
      end
      gld_pkg::ST_FIN: begin
        // the root is the top of the stack: emit it directly
        if (prev_q != gld_pkg::PREV_NONE && nfc_q < NW'(gld_pkg::DICT_SIZE)) begin
          dict_we    = 1'b1;
          dict_wdata = '{prefix: prev_q[CW-1:0], suffix: cur_q[7:0]};
          nfc_n      = nfc_q + NW'(1);
        end
        nfc_d = nfc_n;
        if (nfc_n >= (NW'(1) << cw_q) && cw_q < 4'(gld_pkg::MAX_CODE_BITS)) begin
          cw_d = cw_q + 4'd1;
        end
        first_d      = cur_q[7:0];
        prev_d       = NW'(code_q);
        pix_d        = cur_q[7:0];
        from_stack_d = 1'b0;
      end
      gld_pkg::ST_POP: begin
      end
      gld_pkg::ST_EMIT: begin
        pos_adv              = 1'b1;
        out_valid_d          = 1'b1;
        out_d                = '0;
        out_d.pixel_valid    = 1'b1;
        out_d.pixel_value    = from_stack_q ? stk_rdata : pix_q;
        out_d.pixel_offset   = pos_info.offset;
        out_d.pixel_in_image = pos_info.in_image;
        out_d.stream_ended   = status_q[0];
        out_d.stream_error   = status_q[1];
      end
      default: begin
      end
    endcase

    // code size write restarts the dictionary
    if (cfg_we_i && cfg_addr_i == gld_pkg::CFG_CODE_SIZE) begin
      nfc_d  = NW'(gld_pkg::roots_of(cfg_wdata_i[3:0])) + NW'(2);
      cw_d   = gld_pkg::eff_size(cfg_wdata_i[3:0]) + 4'd1;
      prev_d = gld_pkg::PREV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= gld_pkg::ST_IDLE;
      code_size_q  <= 4'd8;
      width_q      <= 16'd1;
      height_q     <= 16'd1;
      interlaced_q <= 1'b0;
      nfc_q        <= NW'(258);
      cw_q         <= 4'd9;
      prev_q       <= gld_pkg::PREV_NONE;
      first_q      <= '0;
      store_q      <= '0;
      bcnt_q       <= '0;
      sc_q         <= '0;
      status_q     <= '0;
      from_stack_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      nfc_q        <= nfc_d;
      cw_q         <= cw_d;
      prev_q       <= prev_d;
      first_q      <= first_d;
      store_q      <= store_d;
      bcnt_q       <= bcnt_d;
      sc_q         <= sc_d;
      status_q     <= status_d;
      from_stack_q <= from_stack_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          gld_pkg::CFG_CODE_SIZE:  code_size_q  <= cfg_wdata_i[3:0];
          gld_pkg::CFG_WIDTH:      width_q      <= cfg_wdata_i;
          gld_pkg::CFG_HEIGHT:     height_q     <= cfg_wdata_i;
          gld_pkg::CFG_INTERLACED: interlaced_q <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    code_q <= code_d;
    pix_q  <= pix_d;
    out_q  <= out_d;
  end

  // a waiting response blocks only while it is stalled
  assign in_stall_o  = (state_q != gld_pkg::ST_IDLE) || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

/* sv/gld_ram.sv */
module gld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/gld_pos.sv */
// Pixel position: column, row, interlace pass; offset and bounds check.
module gld_pos (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        width_i,
  input  logic [15:0]        height_i,
  input  logic               interlaced_i,
  input  logic               advance_i,
  output gld_pkg::pos_info_t info_o
);

  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic [2:0]  pass_q, pass_d;
  logic [31:0] prod_q, size_q;

  // Products are re-registered every cycle; row and sizes are stable long before use.
  always_ff @(posedge clk_i) begin
    prod_q <= row_q * width_i;
    size_q <= width_i * height_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pass_q <= 3'd1;
    end else if (advance_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      pass_q <= pass_d;
    end
  end

  always_comb begin
    logic [16:0] col_inc;
    logic [16:0] r;
    logic [3:0]  step;
    logic [2:0]  p;
    logic        skip;
    col_inc = {1'b0, col_q} + 17'd1;
    col_d   = col_q;
    row_d   = row_q;
    pass_d  = pass_q;
    step    = 4'd1;
    p       = pass_q;
    r       = '0;
    skip    = 1'b0;
    if (col_inc < {1'b0, width_i}) begin
      col_d = col_inc[15:0];
    end else begin
      col_d = '0;
      if (interlaced_i) begin
        if (pass_q <= 3'd2) step = 4'd8;
        else if (pass_q == 3'd3) step = 4'd4;
        else step = 4'd2;
      end
      r = {1'b0, row_q} + {13'd0, step};
      skip = interlaced_i && (p < 3'd4) && (r >= {1'b0, height_i});
      // At most three passes can be skipped in one row change.
      for (int i = 0; i < 3; i++) begin
        if (skip) begin
          p    = p + 3'd1;
          r    = {13'd0, gld_pkg::pass_start(p)};
          skip = (p < 3'd4) && (r >= {1'b0, height_i});
        end
      end
      pass_d = p;
      row_d  = r[16] ? 16'hFFFF : r[15:0];
    end
  end

  assign info_o.offset   = prod_q + {16'd0, col_q};
  assign info_o.in_image = info_o.offset < size_q;

endmodule

/* sv/gld_checker.sv */
module gld_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input gld_pkg::out_t out_rsp_o
);

  // held response stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("response dropped while stalled");

  // one request in flight: no new request while a response is stalled
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("request taken while response pending");

  // a response is a push ack or a pixel, never both
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.pixel_valid && (out_rsp_o.byte_taken || out_rsp_o.need_data)))
    else $error("mixed response kinds");

  // no-pixel responses carry zero pixel fields
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.pixel_valid |->
      out_rsp_o.pixel_offset == 32'd0 && out_rsp_o.pixel_value == 8'd0 &&
      !out_rsp_o.pixel_in_image)
    else $error("stale pixel fields");

endmodule

bind gif_lzw_pixel_decoder_core gld_checker u_gld_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);
